### rtl/dsed_pkg.sv
// dsed_pkg: shared types and constants of the dle/stx/etx deframer
// byte classification record, result kind codes, register indexes and defaults
// no dependencies
package dsed_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int POS_W  = 11;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_BUFFER_BYTES = 1024;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd2;

    localparam logic [BYTE_W-1:0] RST_START  = 8'd2;
    localparam logic [BYTE_W-1:0] RST_END    = 8'd3;
    localparam logic [BYTE_W-1:0] RST_ESCAPE = 8'd16;

    // one received byte after decoding against the control codes
    typedef struct packed {
        logic              is_start;   // unescaped meaning, start wins over the others
        logic              is_end;
        logic              is_escape;
        logic [BYTE_W-1:0] raw_byte;
        logic [BYTE_W-1:0] esc_byte;   // value to emit when the byte is escaped
    } t_cls;

endpackage

### rtl/dsed_front.sv
// dsed_front: accepts raw bytes, holds the code registers and decodes each beat
// depends on dsed_pkg
module dsed_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dsed_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dsed_pkg::BYTE_W-1:0]    i_cfg_data,
    input  logic                           i_rx_valid,
    output logic                           o_rx_ready,
    input  logic [dsed_pkg::BYTE_W-1:0]    i_rx_byte,
    input  logic                           i_q_full,
    output logic                           o_push,
    output dsed_pkg::t_cls                 o_cls
);
    import dsed_pkg::*;

    logic [BYTE_W-1:0] r_start_code;
    logic [BYTE_W-1:0] r_end_code;
    logic [BYTE_W-1:0] r_escape_code;
    logic [BYTE_W-1:0] end_minus_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code  <= RST_START;
            r_end_code    <= RST_END;
            r_escape_code <= RST_ESCAPE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START:  r_start_code  <= i_cfg_data;
                REG_END:    r_end_code    <= i_cfg_data;
                REG_ESCAPE: r_escape_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign end_minus_one = r_end_code - 8'd1;

    always_comb begin
        o_cls.is_start  = (i_rx_byte == r_start_code);
        o_cls.is_end    = !o_cls.is_start && (i_rx_byte == r_end_code);
        o_cls.is_escape = !o_cls.is_start && !o_cls.is_end && (i_rx_byte == r_escape_code);
        o_cls.raw_byte  = i_rx_byte;
        o_cls.esc_byte  = (i_rx_byte == end_minus_one) ? r_end_code : i_rx_byte;
    end

    assign o_rx_ready = !i_q_full;
    assign o_push     = i_rx_valid && !i_q_full;

endmodule

### rtl/dsed_queue.sv
// dsed_queue: short fifo of decoded beats between front and back
// depends on dsed_pkg
module dsed_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dsed_pkg::t_cls i_cls,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_nonempty,
    output dsed_pkg::t_cls o_cls
);
    import dsed_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_cls             r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_full     = (r_count == FULL_CNT);
    assign o_nonempty = (r_count != '0);
    assign o_cls      = r_entry[r_rd_ptr];
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/dsed_back.sv
// dsed_back: frame state, counters and the result register
// depends on dsed_pkg
module dsed_back #(
    parameter int BUFFER_BYTES = dsed_pkg::DEF_BUFFER_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_nonempty,
    input  dsed_pkg::t_cls              i_cls,
    output logic                        o_pop,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [dsed_pkg::KIND_W-1:0] o_kind,
    output logic [dsed_pkg::BYTE_W-1:0] o_payload_byte,
    output logic [dsed_pkg::POS_W-1:0]  o_position
);
    import dsed_pkg::*;

    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam logic [CW-1:0] BUF_LIMIT = CW'(BUFFER_BYTES);

    logic          r_escape_pending;
    logic          r_start_seen;
    logic [CW-1:0] r_write_index;
    logic [CW-1:0] r_consumed;

    logic              r_res_valid;
    logic [KIND_W-1:0] r_kind;
    logic [BYTE_W-1:0] r_byte;
    logic [POS_W-1:0]  r_pos;

    logic              n_escape_pending;
    logic              n_start_seen;
    logic [CW-1:0]     n_write_index;
    logic [CW-1:0]     n_consumed;
    logic              n_has_res;
    logic [KIND_W-1:0] n_kind;
    logic [BYTE_W-1:0] n_byte;
    logic [CW-1:0]     n_len;

    logic              have_data;
    logic              restart;
    logic [CW-1:0]     wi;
    logic [CW-1:0]     cons;
    logic [BYTE_W-1:0] ch;
    logic [POS_W+CW-1:0] pos_ext;

    assign o_pop = i_q_nonempty && (!r_res_valid || i_res_ready);

    always_comb begin
        cons      = r_consumed + 1'b1;
        wi        = r_write_index;
        have_data = 1'b0;
        restart   = 1'b0;
        ch        = i_cls.raw_byte;
        n_has_res = 1'b0;
        n_kind    = KIND_DATA;
        n_byte    = '0;
        n_len     = '0;
        n_escape_pending = r_escape_pending;
        n_start_seen     = r_start_seen;

        if (!r_escape_pending) begin
            if (i_cls.is_start) begin
                if (r_start_seen) begin
                    n_has_res = 1'b1;
                    n_kind    = KIND_ERR;
                    restart   = 1'b1;
                end else begin
                    n_start_seen = 1'b1;
                    wi           = '0;
                end
            end else if (i_cls.is_end) begin
                n_has_res = 1'b1;
                n_kind    = KIND_DONE;
                n_len     = r_write_index;
                restart   = 1'b1;
            end else if (i_cls.is_escape) begin
                n_escape_pending = 1'b1;
            end else begin
                have_data = 1'b1;
            end
        end else begin
            n_escape_pending = 1'b0;
            ch               = i_cls.esc_byte;
            have_data        = 1'b1;
        end

        if (!restart) begin
            // index guard, then the buffer limit, then plain data
            if (have_data && (wi >= BUF_LIMIT)) begin
                n_has_res = 1'b1;
                n_kind    = KIND_ERR;
                restart   = 1'b1;
            end else if (cons >= BUF_LIMIT) begin
                n_has_res = 1'b1;
                n_kind    = KIND_DONE;
                n_len     = wi + CW'(have_data);
                restart   = 1'b1;
            end else if (have_data) begin
                n_has_res = 1'b1;
                n_kind    = KIND_DATA;
                n_byte    = ch;
                n_len     = wi;
                wi        = wi + 1'b1;
            end
        end

        if (restart) begin
            n_escape_pending = 1'b0;
            n_start_seen     = 1'b0;
            n_write_index    = '0;
            n_consumed       = '0;
        end else begin
            n_write_index = wi;
            n_consumed    = cons;
        end

        pos_ext = {{POS_W{1'b0}}, n_len};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_pending <= 1'b0;
            r_start_seen     <= 1'b0;
            r_write_index    <= '0;
            r_consumed       <= '0;
            r_res_valid      <= 1'b0;
        end else if (o_pop) begin
            r_escape_pending <= n_escape_pending;
            r_start_seen     <= n_start_seen;
            r_write_index    <= n_write_index;
            r_consumed       <= n_consumed;
            r_res_valid      <= n_has_res;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && n_has_res) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_pos  <= pos_ext[POS_W-1:0];
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_kind         = r_kind;
    assign o_payload_byte = r_byte;
    assign o_position     = r_pos;

endmodule

### rtl/dle_stx_etx_deframer_unit.sv
// Byte unstuffing deframer for DLE/STX/ETX framed streams. One received byte is
// accepted per clock while the queue is not full. A result is a data byte with
// its write index, a frame complete with its length, or a frame error. A byte
// goes to the queue, then the back part registers its result at the output.
// Bytes that only change state (start, escape) give no result. The back part
// sets the rate: it updates the frame state and counters for one queued byte
// per cycle while its result register is free or being taken. A two-entry
// queue links the decoder and back part. While a result waits on the output
// side, two more beats are taken before the input stalls. The user must write
// code registers (index 0 start, 1 end, 2 escape) only while idle; not enforced.
// Depends on dsed_pkg, dsed_front, dsed_queue and dsed_back.
module dle_stx_etx_deframer_unit #(
    parameter int BUFFER_BYTES = dsed_pkg::DEF_BUFFER_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dsed_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dsed_pkg::BYTE_W-1:0]    i_cfg_data,
    input  logic                           i_rx_valid,
    output logic                           o_rx_ready,
    input  logic [dsed_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output logic [dsed_pkg::KIND_W-1:0]    o_kind,
    output logic [dsed_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic [dsed_pkg::POS_W-1:0]     o_position
);
    import dsed_pkg::*;

    t_cls front_cls;
    t_cls queue_cls;
    logic push;
    logic pop;
    logic q_full;
    logic q_nonempty;

    dsed_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cls       (front_cls)
    );

    dsed_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cls      (front_cls),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_cls      (queue_cls)
    );

    dsed_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_nonempty   (q_nonempty),
        .i_cls          (queue_cls),
        .o_pop          (pop),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_position     (o_position)
    );

endmodule

### sim/dle_stx_etx_deframer_unit_test.sv
// dle_stx_etx_deframer_unit_test: self-checking bench for the dle/stx/etx byte deframer
// sends framed, broken and noisy byte streams under several code settings, checks each result
// depends on dsed_pkg and dle_stx_etx_deframer_unit
module dle_stx_etx_deframer_unit_test;
    import dsed_pkg::*;

    localparam int BUF_BYTES      = DEF_BUFFER_BYTES;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        byte_t             payload;
        logic [POS_W-1:0]  pos;
    } beat_t;

    // tracks the unstuffing state and holds the result beats still to come
    class deframe_tracker;
        byte_t start_code;
        byte_t end_code;
        byte_t esc_code;
        bit    esc_pending;
        bit    in_frame;
        int    write_idx;
        int    consumed;
        beat_t pending[$];
        int    errors;

        function new();
            start_code = RST_START;
            end_code   = RST_END;
            esc_code   = RST_ESCAPE;
            errors     = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            esc_pending = 1'b0;
            in_frame    = 1'b0;
            write_idx   = 0;
            consumed    = 0;
        endfunction

        function void set_code(logic [CFG_IDX_W-1:0] idx, byte_t val);
            case (idx)
                REG_START:  start_code = val;
                REG_END:    end_code   = val;
                REG_ESCAPE: esc_code   = val;
                default: ;
            endcase
        endfunction

        function void push(logic [KIND_W-1:0] kind, byte_t payload, int pos);
            beat_t b;
            b.kind    = kind;
            b.payload = payload;
            b.pos     = POS_W'(pos);
            pending.push_back(b);
        endfunction

        function void take_rx_byte(byte_t rx);
            byte_t ch;
            bit    is_data;
            int    len;
            ch      = rx;
            is_data = 1'b0;
            consumed++;
            if (!esc_pending) begin
                // start beats end beats escape when codes are equal
                if (ch == start_code) begin
                    if (in_frame) begin
                        clear_frame();
                        push(KIND_ERR, '0, 0);
                        return;
                    end
                    in_frame  = 1'b1;
                    write_idx = 0;
                end else if (ch == end_code) begin
                    len = write_idx;
                    clear_frame();
                    push(KIND_DONE, '0, len);
                    return;
                end else if (ch == esc_code) begin
                    esc_pending = 1'b1;
                end else begin
                    is_data = 1'b1;
                end
            end else begin
                esc_pending = 1'b0;
                if (ch == byte_t'(end_code - 1)) ch = end_code;
                is_data = 1'b1;
            end
            if (is_data && write_idx >= BUF_BYTES) begin
                clear_frame();
                push(KIND_ERR, '0, 0);
                return;
            end
            // consumed byte limit: this byte closes the frame in place of any data beat
            if (consumed >= BUF_BYTES) begin
                len = write_idx + int'(is_data);
                clear_frame();
                push(KIND_DONE, '0, len);
                return;
            end
            if (is_data) begin
                push(KIND_DATA, ch, write_idx);
                write_idx++;
            end
        endfunction

        function void check_result(logic [KIND_W-1:0] kind, byte_t payload,
                                   logic [POS_W-1:0] pos);
            beat_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat kind %0d byte %0h position %0d",
                         $time, kind, payload, pos);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (kind !== exp.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, exp.kind, kind);
                errors++;
            end
            if (payload !== exp.payload) begin
                $display("%0t: payload_byte expected %0h actual %0h", $time, exp.payload, payload);
                errors++;
            end
            if (pos !== exp.pos) begin
                $display("%0t: position expected %0d actual %0d", $time, exp.pos, pos);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n      = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    byte_t                cfg_data     = '0;
    logic                 rx_valid     = 1'b0;
    byte_t                rx_byte      = '0;
    logic                 rx_ready;
    logic                 res_valid;
    logic                 res_ready    = 1'b0;
    logic [KIND_W-1:0]    kind;
    byte_t                payload_byte;
    logic [POS_W-1:0]     position;

    bit quiet_tail  = 1'b0;
    bit hold_req    = 1'b0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int sent_count  = 0;

    deframe_tracker tracker = new();

    byte_t directed_bytes [23] = '{
        8'h00, 8'hFF, 8'h02, 8'h41, 8'h10, 8'h02, 8'h10, 8'h10, 8'h10, 8'h03, 8'h10, 8'h80,
        8'h7F, 8'h03, 8'h02, 8'h02, 8'h55, 8'h03, 8'h02, 8'h03, 8'h10, 8'hFF, 8'h03
    };

    dle_stx_etx_deframer_unit #(
        .BUFFER_BYTES(BUF_BYTES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_rx_valid     (rx_valid),
        .o_rx_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_kind         (kind),
        .o_payload_byte (payload_byte),
        .o_position     (position)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                res_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                res_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 7);
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_valid && res_ready) tracker.check_result(kind, payload_byte, position);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_valid && rx_ready) || (res_valid && res_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("dle_stx_etx_deframer_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input byte_t b);
        @(negedge i_clk);
        if (!quiet_tail && $urandom_range(0, 11) == 0) begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge i_clk); while (!rx_ready);
        tracker.take_rx_byte(b);
        sent_count++;
    endtask

    function automatic bit is_code(byte_t b);
        return b == tracker.start_code || b == tracker.end_code || b == tracker.esc_code;
    endfunction

    // control codes always go escaped, other bytes now and then
    task automatic send_payload(input byte_t b);
        if (is_code(b) || $urandom_range(0, 7) == 0) send_byte(tracker.esc_code);
        send_byte(b);
    endtask

    task automatic send_traffic(input int n);
        int stop_at;
        int pick;
        int code_pick;
        stop_at = sent_count + n;
        while (sent_count < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
                send_byte(tracker.start_code);
                repeat ($urandom_range(0, 12)) begin
                    case ($urandom_range(0, 5))
                        0: send_payload(byte_t'(tracker.end_code - 1));
                        1: begin
                            code_pick = $urandom_range(0, 2);
                            send_payload(code_pick == 0 ? tracker.start_code :
                                         code_pick == 1 ? tracker.end_code : tracker.esc_code);
                        end
                        default: send_payload(byte_t'($urandom_range(0, 255)));
                    endcase
                end
                send_byte(tracker.end_code);
            end else if (pick == 7) begin
                repeat ($urandom_range(1, 6)) send_byte(byte_t'($urandom_range(0, 255)));
            end else if (pick == 8) begin
                send_byte(tracker.start_code);
                repeat ($urandom_range(0, 3)) send_payload(byte_t'($urandom_range(0, 255)));
                send_byte(tracker.start_code);
            end else begin
                // no start code, or a dangling escape that swallows the end code
                repeat ($urandom_range(0, 4)) send_payload(byte_t'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 1) send_byte(tracker.esc_code);
                send_byte(tracker.end_code);
            end
        end
    endtask

    // a frame with no end code, long enough to run into the buffer limit
    task automatic send_long_frame(input int n);
        byte_t b;
        bit    escaped;
        escaped = 1'b0;
        send_byte(tracker.end_code);
        send_byte(tracker.start_code);
        repeat (n) begin
            do b = byte_t'($urandom_range(0, 255));
            while (!escaped && (b == tracker.start_code || b == tracker.end_code));
            send_byte(b);
            escaped = !escaped && (b == tracker.esc_code);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        rx_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        // bytes with no result may still be in flight
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_code(input logic [CFG_IDX_W-1:0] idx, input byte_t val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        tracker.set_code(idx, val);
    endtask

    task automatic set_codes(input byte_t s, input byte_t e, input byte_t x);
        set_code(REG_START, s);
        set_code(REG_END, e);
        set_code(REG_ESCAPE, x);
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
        drain();

        set_codes(8'h00, 8'hFF, 8'h80);
        send_traffic(150);
        drain();

        // end minus one wraps onto the start code here
        set_codes(8'hFF, 8'h00, 8'h7F);
        hold_req = 1'b1;
        send_traffic(150);
        drain();

        set_codes(8'h55, 8'h55, 8'h55);
        send_traffic(40);
        drain();
        set_codes(8'h10, 8'h10, 8'h20);
        send_traffic(40);
        drain();
        set_codes(8'h02, 8'h33, 8'h33);
        send_traffic(40);
        drain();

        repeat (2) begin
            set_codes(byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
                      byte_t'($urandom_range(0, 255)));
            send_traffic(50);
            drain();
        end

        set_codes(RST_START, RST_END, RST_ESCAPE);
        send_long_frame(1030);
        drain();

        quiet_tail = 1'b1;
        send_traffic(60);
        drain();

        if (tracker.outstanding() != 0)
            $display("%0t: %0d result beats never arrived", $time, tracker.outstanding());
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("dle_stx_etx_deframer_unit: match");
        else
            $display("dle_stx_etx_deframer_unit: mismatch");
        $finish;
    end

endmodule

### sim.f
rtl/dsed_pkg.sv
rtl/dsed_front.sv
rtl/dsed_queue.sv
rtl/dsed_back.sv
rtl/dle_stx_etx_deframer_unit.sv
sim/dle_stx_etx_deframer_unit_test.sv
